FILE: hdl/rfe_pkg.sv
package rfe_pkg;

  // Field and datapath widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DAYS_W = 17;   // days since epoch, below 2**17 for years up to 2255
  localparam int unsigned SEC_W  = 34;   // seconds since epoch
  localparam int unsigned HALF_W = 17;   // seconds split for the scaling multiply
  localparam int unsigned PROD_W = 47;   // half-seconds times ns-per-second
  localparam int unsigned NS_W   = 63;

  // Calendar constants
  localparam logic [DAYS_W-1:0] DAYS_TO_2000 = 17'd10957;  // 1970-01-01 to 2000-01-01
  localparam logic [SEC_W-1:0]  SEC_PER_DAY  = 34'd86400;
  localparam logic [SEC_W-1:0]  SEC_PER_HOUR = 34'd3600;
  localparam logic [SEC_W-1:0]  SEC_PER_MIN  = 34'd60;
  localparam logic [PROD_W-1:0] NS_PER_SEC   = 47'd1000000000;
  localparam logic [BYTE_W-1:0] MONTH_FEB    = 8'd2;
  localparam logic [BYTE_W-1:0] MONTH_DEC    = 8'd12;
  localparam logic [BYTE_W-1:0] YEAR_2100    = 8'd100;
  localparam logic [BYTE_W-1:0] YEAR_2200    = 8'd200;

  // Reset value of the coding register
  localparam logic BCD_MODE_RST = 1'b1;

  // Raw or decoded clock snapshot
  typedef struct packed {
    logic [BYTE_W-1:0] year;
    logic [BYTE_W-1:0] month;
    logic [BYTE_W-1:0] day;
    logic [BYTE_W-1:0] hours;
    logic [BYTE_W-1:0] minutes;
    logic [BYTE_W-1:0] seconds;
  } snap_t;

  // Day count plus time of day
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [BYTE_W-1:0] hours;
    logic [BYTE_W-1:0] minutes;
    logic [BYTE_W-1:0] seconds;
    logic              date_error;
  } cal_t;

  // Final result
  typedef struct packed {
    logic [NS_W-1:0] epoch_ns;
    logic            date_error;
  } res_t;

  // Days in the year before the first of month m (1..12)
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of month m (1..12) in a common year
  function automatic logic [4:0] month_length(input logic [3:0] m);
    logic [4:0] l;
    unique case (m)
      4'd2:                      l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
      default:                   l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

FILE: hdl/rfe_snap_if.sv
interface rfe_snap_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_byte;
  logic [7:0] month_byte;
  logic [7:0] day_byte;
  logic [7:0] hours_byte;
  logic [7:0] minutes_byte;
  logic [7:0] seconds_byte;

  modport source (
    output valid, year_byte, month_byte, day_byte, hours_byte, minutes_byte, seconds_byte,
    input  ready
  );
  modport sink (
    input  valid, year_byte, month_byte, day_byte, hours_byte, minutes_byte, seconds_byte,
    output ready
  );
endinterface

FILE: hdl/rfe_epoch_if.sv
interface rfe_epoch_if;
  logic        valid;
  logic        ready;
  logic [62:0] epoch_ns;
  logic        date_error;

  modport source (output valid, epoch_ns, date_error, input ready);
  modport sink (input valid, epoch_ns, date_error, output ready);
endinterface

FILE: hdl/rfe_cfg_if.sv
interface rfe_cfg_if;
  logic valid;
  logic ready;
  logic bcd_mode;

  modport source (output valid, bcd_mode, input ready);
  modport sink (input valid, bcd_mode, output ready);
endinterface

FILE: hdl/rfe_decode.sv
module rfe_decode import rfe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  logic  bcd_mode_i,
  input  logic  valid_i,
  input  snap_t raw_i,
  output logic  valid_o,
  output snap_t dec_o
);

  logic  valid_q;
  snap_t dec_d, dec_q;

  // In BCD mode low nibble plus ten times high nibble, nibbles above nine taken as they are; else b unchanged
  function automatic logic [BYTE_W-1:0] decode(input logic [BYTE_W-1:0] b, input logic bcd);
    logic [BYTE_W-1:0] v;
    if (bcd) begin
      v = BYTE_W'(b[3:0]) + BYTE_W'(b[7:4]) * BYTE_W'(10);
    end else begin
      v = b;
    end
    return v;
  endfunction

  // Decode every byte of the snapshot
  always_comb begin
    dec_d.year    = decode(raw_i.year, bcd_mode_i);
    dec_d.month   = decode(raw_i.month, bcd_mode_i);
    dec_d.day     = decode(raw_i.day, bcd_mode_i);
    dec_d.hours   = decode(raw_i.hours, bcd_mode_i);
    dec_d.minutes = decode(raw_i.minutes, bcd_mode_i);
    dec_d.seconds = decode(raw_i.seconds, bcd_mode_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

FILE: hdl/rfe_calendar.sv
module rfe_calendar import rfe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  logic  valid_i,
  input  snap_t dec_i,
  output logic  valid_o,
  output cal_t  cal_o
);

  logic              valid_q;
  cal_t              cal_d, cal_q;
  logic              leap;
  logic              month_bad;
  logic              day_bad;
  logic [4:0]        mlen;
  logic [8:0]        yv_p3;
  logic [6:0]        leaps_before;
  logic [DAYS_W-1:0] days;

  // Leap years of 2000..2255: every fourth, except 2100 and 2200
  assign leap = (dec_i.year[1:0] == 2'b00) && (dec_i.year != YEAR_2100) &&
                (dec_i.year != YEAR_2200);

  // Check month and day against the month length
  always_comb begin
    month_bad = (dec_i.month == '0) || (dec_i.month > MONTH_DEC);
    mlen      = month_length(dec_i.month[3:0]) +
                5'((leap && dec_i.month == MONTH_FEB) ? 1 : 0);
    day_bad   = (dec_i.day == '0) || (dec_i.day > BYTE_W'(mlen));
  end

  // Leap days in the years from 2000 up to the one before
  assign yv_p3        = {1'b0, dec_i.year} + 9'd3;
  assign leaps_before = yv_p3[8:2] - 7'(dec_i.year > YEAR_2100) - 7'(dec_i.year > YEAR_2200);

  // Count days since the epoch
  always_comb begin
    days = DAYS_TO_2000
         + DAYS_W'(dec_i.year) * DAYS_W'(365)
         + DAYS_W'(leaps_before)
         + DAYS_W'(days_before_month(dec_i.month[3:0]))
         + DAYS_W'((leap && dec_i.month > MONTH_FEB) ? 1 : 0)
         + DAYS_W'(dec_i.day) - DAYS_W'(1);
    cal_d.date_error = month_bad || day_bad;
    cal_d.days       = cal_d.date_error ? '0 : days;
    cal_d.hours      = dec_i.hours;
    cal_d.minutes    = dec_i.minutes;
    cal_d.seconds    = dec_i.seconds;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      cal_q <= cal_d;
    end
  end

  assign valid_o = valid_q;
  assign cal_o   = cal_q;

endmodule

FILE: hdl/rfe_scale.sv
module rfe_scale import rfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  input  logic valid_i,
  input  cal_t cal_i,
  output logic valid_o,
  output res_t res_o
);

  logic [2:0]        valid_q;
  logic [SEC_W-1:0]  sec_d, sec_q;
  logic              err3_q, err4_q;
  logic [PROD_W-1:0] lo_q, hi_q;
  res_t              res_d, res_q;

  // Seconds since epoch, zero on a bad date
  always_comb begin
    sec_d = SEC_W'(cal_i.days) * SEC_PER_DAY
          + SEC_W'(cal_i.hours) * SEC_PER_HOUR
          + SEC_W'(cal_i.minutes) * SEC_PER_MIN
          + SEC_W'(cal_i.seconds);
    if (cal_i.date_error) begin
      sec_d = '0;
    end
  end

  // Join the two partial products
  always_comb begin
    res_d.epoch_ns   = (NS_W'(hi_q) << HALF_W) + NS_W'(lo_q);
    res_d.date_error = err4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Seconds, then split scaling, then sum
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sec_q  <= sec_d;
      err3_q <= cal_i.date_error;
      lo_q   <= PROD_W'(sec_q[HALF_W-1:0]) * NS_PER_SEC;
      hi_q   <= PROD_W'(sec_q[SEC_W-1:HALF_W]) * NS_PER_SEC;
      err4_q <= err3_q;
      res_q  <= res_d;
    end
  end

  assign valid_o = valid_q[2];
  assign res_o   = res_q;

endmodule

FILE: hdl/rtc_fields_to_epoch_ns.sv
// Channel   Dir  Beat contents
// cfg_i     in   bcd_mode (1 = clock bytes are BCD)
// snap_i    in   year, month, day, hours, minutes, seconds bytes
// epoch_o   out  epoch_ns (63 bits), date_error
//
// Five register stages: decode, calendar, seconds, split multiply, sum.
// One snapshot is taken each cycle when not stalled.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears the stage valid bits and sets bcd_mode to one.
module rtc_fields_to_epoch_ns import rfe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rfe_cfg_if.sink      cfg_i,
  rfe_snap_if.sink     snap_i,
  rfe_epoch_if.source  epoch_o
);

  logic  bcd_mode_q;
  logic  advance;
  logic  dec_valid, cal_valid, res_valid;
  snap_t raw;
  snap_t dec;
  cal_t  cal;
  res_t  res;

  // Configuration register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_mode_q <= BCD_MODE_RST;
    end else if (cfg_i.valid) begin
      bcd_mode_q <= cfg_i.bcd_mode;
    end
  end

  // Advance all stages unless the output beat is held
  assign advance      = !res_valid || epoch_o.ready;
  assign snap_i.ready = advance;

  assign raw = {snap_i.year_byte, snap_i.month_byte, snap_i.day_byte,
                snap_i.hours_byte, snap_i.minutes_byte, snap_i.seconds_byte};

  rfe_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .bcd_mode_i (bcd_mode_q),
    .valid_i    (snap_i.valid),
    .raw_i      (raw),
    .valid_o    (dec_valid),
    .dec_o      (dec)
  );

  rfe_calendar u_calendar (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (dec_valid),
    .dec_i     (dec),
    .valid_o   (cal_valid),
    .cal_o     (cal)
  );

  rfe_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (cal_valid),
    .cal_i     (cal),
    .valid_o   (res_valid),
    .res_o     (res)
  );

  assign epoch_o.valid      = res_valid;
  assign epoch_o.epoch_ns   = res.epoch_ns;
  assign epoch_o.date_error = res.date_error;

  // A bad date always yields a zero time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (epoch_o.valid && epoch_o.date_error) |-> (epoch_o.epoch_ns == '0))
    else $error("date error beat carries nonzero time");

  // An accepted beat shows at the output, after passing every register stage, when never stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(snap_i.valid && snap_i.ready, 5) && $past(rst_ni, 5) && $past(rst_ni, 4) &&
     $past(rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1) &&
     $past(epoch_o.ready, 4) && $past(epoch_o.ready, 3) &&
     $past(epoch_o.ready, 2) && $past(epoch_o.ready, 1)) |-> epoch_o.valid)
    else $error("accepted beat lost in pipeline");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rfe_pkg::*;

  typedef enum bit {
    CODING_BINARY = 1'b0,
    CODING_BCD    = 1'b1
  } coding_e;

  localparam int unsigned      CLK_HALF   = 4;
  localparam int unsigned      RST_CYCLES = 6;
  localparam int unsigned      IDLE_PCT   = 24;
  localparam int unsigned      SETTLE     = 10;
  localparam int unsigned      CYCLE_CAP  = 200000;
  localparam longint unsigned  NANOS      = 64'd1000000000;

  logic clk;
  logic rst_n;

  rfe_cfg_if   cfg_bus ();
  rfe_snap_if  snap_bus ();
  rfe_epoch_if epoch_bus ();

  rtc_fields_to_epoch_ns u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_bus),
    .snap_i  (snap_bus),
    .epoch_o (epoch_bus)
  );

  snap_t   snap_pending[$];
  res_t    epoch_expected[$];
  coding_e coding_q;
  logic    snap_taken;
  logic    cfg_taken;
  bit      no_idle;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned snaps_sent;
  int unsigned results_seen;
  int unsigned bad_dates;
  int unsigned coding_writes;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  function automatic int unsigned month_days(input int unsigned yr, input int unsigned mo);
    int unsigned len;
    case (mo)
      2:             len = leap_year(yr) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // Nibble decode applies to any byte in BCD coding, digits above nine included; binary returns it as is
  function automatic int unsigned decode_byte(input logic [7:0] raw, input coding_e coding);
    if (coding == CODING_BCD) begin
      return raw[3:0] + 10 * raw[7:4];
    end
    return raw;
  endfunction

  function automatic logic [7:0] encode_byte(input int unsigned val, input coding_e coding);
    logic [7:0] b;
    if (coding == CODING_BCD) begin
      b = {4'(val / 10), 4'(val % 10)};
    end else begin
      b = 8'(val);
    end
    return b;
  endfunction

  // Expected result for one snapshot: walk whole years and months from 1970
  function automatic res_t predict_epoch(input snap_t raw, input coding_e coding);
    int unsigned     yr;
    int unsigned     mo;
    int unsigned     dy;
    int unsigned     days;
    longint unsigned secs;
    longint unsigned ns;
    res_t            r;
    yr = 2000 + decode_byte(raw.year, coding);
    mo = decode_byte(raw.month, coding);
    dy = decode_byte(raw.day, coding);
    r.epoch_ns   = '0;
    r.date_error = 1'b1;
    if (mo >= 1 && mo <= 12 && dy >= 1 && dy <= month_days(yr, mo)) begin
      days = 0;
      for (int unsigned y = 1970; y < yr; y++) days += leap_year(y) ? 366 : 365;
      for (int unsigned m = 1; m < mo; m++) days += month_days(yr, m);
      days += dy - 1;
      secs = longint'(days) * 86400
           + longint'(decode_byte(raw.hours, coding)) * 3600
           + longint'(decode_byte(raw.minutes, coding)) * 60
           + longint'(decode_byte(raw.seconds, coding));
      ns = secs * NANOS;
      r.epoch_ns   = ns[62:0];
      r.date_error = 1'b0;
    end
    return r;
  endfunction

  function automatic bit take_break();
    return !no_idle && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Mostly well-formed dates with random content, month-end edges, and some raw noise
  function automatic snap_t make_snap(input coding_e coding);
    snap_t       s;
    int unsigned yr;
    int unsigned mo;
    int unsigned len;
    int unsigned pick;
    if ($urandom_range(99) < 20) begin
      s = $bits(snap_t)'({$urandom, $urandom});
      return s;
    end
    if (coding == CODING_BCD && $urandom_range(99) < 80) begin
      s.year = encode_byte($urandom_range(99), coding);
    end else begin
      s.year = 8'($urandom);
    end
    yr  = 2000 + decode_byte(s.year, coding);
    mo  = $urandom_range(12, 1);
    len = month_days(yr, mo);
    s.month = encode_byte(mo, coding);
    pick = $urandom_range(7);
    case (pick)
      0:       s.day = encode_byte(1, coding);
      1:       s.day = encode_byte(len, coding);
      2:       s.day = encode_byte(len + 1, coding);
      default: s.day = encode_byte($urandom_range(len, 1), coding);
    endcase
    if ($urandom_range(99) < 85) begin
      s.hours   = encode_byte($urandom_range(23), coding);
      s.minutes = encode_byte($urandom_range(59), coding);
      s.seconds = encode_byte($urandom_range(59), coding);
    end else begin
      s.hours   = 8'($urandom);
      s.minutes = 8'($urandom);
      s.seconds = 8'($urandom);
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic queue_snap(input logic [7:0] yr, input logic [7:0] mo, input logic [7:0] dy,
                            input logic [7:0] hh, input logic [7:0] mi, input logic [7:0] ss);
    snap_t s;
    s.year    = yr;
    s.month   = mo;
    s.day     = dy;
    s.hours   = hh;
    s.minutes = mi;
    s.seconds = ss;
    snap_pending.push_back(s);
  endtask

  task automatic queue_random(input int unsigned count, input coding_e coding);
    repeat (count) snap_pending.push_back(make_snap(coding));
  endtask

  // Wait for every beat to go out and every result to come back, then let the pipe settle
  task automatic drain();
    while (snap_pending.size() != 0 || epoch_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_coding(input coding_e coding);
    @(negedge clk);
    cfg_bus.valid    <= 1'b1;
    cfg_bus.bcd_mode <= coding;
    do @(negedge clk); while (!cfg_taken);
    cfg_bus.valid <= 1'b0;
    coding_writes++;
  endtask

  // Snapshot driver: hold a beat until taken, then advance
  always @(negedge clk) begin : snap_drive
    logic hold;
    hold = snap_bus.valid && !snap_taken;
    if (!rst_n) begin
      snap_bus.valid <= 1'b0;
    end else begin
      if (snap_bus.valid && snap_taken) void'(snap_pending.pop_front());
      if (!hold) begin
        if (snap_pending.size() != 0 && !take_break()) begin
          snap_bus.valid        <= 1'b1;
          snap_bus.year_byte    <= snap_pending[0].year;
          snap_bus.month_byte   <= snap_pending[0].month;
          snap_bus.day_byte     <= snap_pending[0].day;
          snap_bus.hours_byte   <= snap_pending[0].hours;
          snap_bus.minutes_byte <= snap_pending[0].minutes;
          snap_bus.seconds_byte <= snap_pending[0].seconds;
        end else begin
          snap_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    epoch_bus.ready <= rst_n && !take_break();
  end

  // Track accepted beats and predict their results
  always @(posedge clk or negedge rst_n) begin : accept_side
    snap_t beat;
    res_t  want;
    if (!rst_n) begin
      snap_taken <= 1'b0;
      cfg_taken  <= 1'b0;
      coding_q   <= CODING_BCD;
    end else begin
      snap_taken <= snap_bus.valid && snap_bus.ready;
      cfg_taken  <= cfg_bus.valid && cfg_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) coding_q <= coding_e'(cfg_bus.bcd_mode);
      if (snap_bus.valid && snap_bus.ready) begin
        beat.year    = snap_bus.year_byte;
        beat.month   = snap_bus.month_byte;
        beat.day     = snap_bus.day_byte;
        beat.hours   = snap_bus.hours_byte;
        beat.minutes = snap_bus.minutes_byte;
        beat.seconds = snap_bus.seconds_byte;
        want = predict_epoch(beat, coding_q);
        epoch_expected.push_back(want);
        snaps_sent++;
        if (want.date_error) bad_dates++;
      end
    end
  end

  // Compare each result beat with the oldest prediction; bound the run
  always @(posedge clk) begin : epoch_check
    res_t want;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
        $display("Timed out after %0d cycles, %0d results outstanding",
                 cycle_count, epoch_expected.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else if (epoch_bus.valid && epoch_bus.ready) begin
        if (epoch_expected.size() == 0) begin
          report_mismatch("unexpected result beat, epoch_ns", 64'(epoch_bus.epoch_ns), 0);
        end else begin
          want = epoch_expected.pop_front();
          results_seen++;
          if (epoch_bus.epoch_ns !== want.epoch_ns)
            report_mismatch("epoch_ns", 64'(epoch_bus.epoch_ns), 64'(want.epoch_ns));
          if (epoch_bus.date_error !== want.date_error)
            report_mismatch("date_error", 64'(epoch_bus.date_error), 64'(want.date_error));
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_n                 = 1'b0;
    no_idle               = 1'b0;
    cycle_count           = 0;
    error_count           = 0;
    snaps_sent            = 0;
    results_seen          = 0;
    bad_dates             = 0;
    coding_writes         = 0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.bcd_mode      = 1'b1;
    snap_bus.valid        = 1'b0;
    snap_bus.year_byte    = '0;
    snap_bus.month_byte   = '0;
    snap_bus.day_byte     = '0;
    snap_bus.hours_byte   = '0;
    snap_bus.minutes_byte = '0;
    snap_bus.seconds_byte = '0;
    epoch_bus.ready       = 1'b0;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // BCD coding straight out of reset
    queue_snap(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);  // start of 2000
    queue_snap(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);  // last second of 2099
    queue_snap(8'h00, 8'h02, 8'h29, 8'h12, 8'h30, 8'h00);  // leap day, year divisible by 400
    queue_snap(8'h01, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00);  // leap day in a common year
    queue_snap(8'h24, 8'h02, 8'h29, 8'h01, 8'h02, 8'h03);  // leap day, ordinary leap year
    queue_snap(8'h24, 8'h03, 8'h01, 8'hff, 8'hff, 8'hff);  // time bytes with bad nibbles
    queue_snap(8'h10, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00);  // month zero
    queue_snap(8'h10, 8'h13, 8'h10, 8'h00, 8'h00, 8'h00);  // month thirteen
    queue_snap(8'h10, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00);  // day zero
    queue_snap(8'h10, 8'h04, 8'h31, 8'h00, 8'h00, 8'h00);  // past end of a 30-day month
    queue_snap(8'h10, 8'h0a, 8'h0f, 8'h00, 8'h00, 8'h00);  // bad nibbles that decode in range
    queue_snap(8'ha0, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00);  // 2100 is not a leap year
    queue_snap(8'hff, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);  // largest decoded year
    queue_snap(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);  // all ones
    drain();

    // Plain binary coding
    write_coding(CODING_BINARY);
    queue_snap(8'd0,   8'd1,  8'd1,  8'd0,   8'd0,   8'd0);
    queue_snap(8'd255, 8'd12, 8'd31, 8'd255, 8'd255, 8'd255);  // largest total
    queue_snap(8'd100, 8'd2,  8'd29, 8'd0,   8'd0,   8'd0);    // 2100, no leap day
    queue_snap(8'd200, 8'd2,  8'd29, 8'd0,   8'd0,   8'd0);    // 2200, no leap day
    queue_snap(8'd104, 8'd2,  8'd29, 8'd23,  8'd59,  8'd59);
    queue_snap(8'd50,  8'd13, 8'd1,  8'd0,   8'd0,   8'd0);
    queue_snap(8'd50,  8'd11, 8'd31, 8'd0,   8'd0,   8'd0);
    queue_snap(8'd50,  8'd0,  8'd0,  8'd0,   8'd0,   8'd0);
    queue_snap(8'h12,  8'h09, 8'h30, 8'h23,  8'h59,  8'h59);   // BCD-looking bytes read as binary
    drain();

    // Random phases with alternating coding
    write_coding(CODING_BCD);
    queue_random(180, CODING_BCD);
    drain();

    write_coding(CODING_BINARY);
    queue_random(180, CODING_BINARY);
    drain();

    // Full throughput on both sides
    write_coding(CODING_BCD);
    no_idle = 1'b1;
    queue_random(120, CODING_BCD);
    drain();
    no_idle = 1'b0;

    write_coding(CODING_BINARY);
    queue_random(100, CODING_BINARY);
    drain();

    $display("Sent %0d clock snapshots over %0d coding changes;", snaps_sent, coding_writes);
    $display("%0d results checked, %0d bad dates.", results_seen, bad_dates);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: rtc_fields_to_epoch_ns.f
hdl/rfe_pkg.sv
hdl/rfe_snap_if.sv
hdl/rfe_epoch_if.sv
hdl/rfe_cfg_if.sv
hdl/rfe_decode.sv
hdl/rfe_calendar.sv
hdl/rfe_scale.sv
hdl/rtc_fields_to_epoch_ns.sv
bench/tb_top.sv
